// ===== src/thba_pkg.sv =====
// ----------------------------------------------------------------------------
// thba_pkg: shared definitions for the two-heap block map allocator
// Heap geometry, field widths, block marks, action and status codes, the
// controller state type and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package thba_pkg;

    // Heap geometry
    localparam int LARGE_BLOCKS      = 256;
    localparam int SMALL_BLOCKS      = 256;
    localparam int LARGE_BLOCK_SHIFT = 12;
    localparam int SMALL_BLOCK_SHIFT = 6;

    // Field widths
    localparam int ADDR_W   = 48;
    localparam int BYTES_W  = 32;
    localparam int ID_W     = 9;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int MARK_W   = 3;

    // Map indexing
    localparam int MAX_BLOCKS = (LARGE_BLOCKS > SMALL_BLOCKS) ? LARGE_BLOCKS : SMALL_BLOCKS;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int L_IDX_W    = $clog2(LARGE_BLOCKS);
    localparam int S_IDX_W    = $clog2(SMALL_BLOCKS);

    // Address arithmetic carries two extra bits: one for base plus heap
    // size, one so that a borrow shows up as a huge difference.
    localparam int EXT_W  = ADDR_W + 2;
    localparam int SIZE_W = BYTES_W + 1;
    localparam int INT_W  = 32;

    localparam logic [EXT_W-1:0] SMALL_HEAP_SIZE = EXT_W'(SMALL_BLOCKS) << SMALL_BLOCK_SHIFT;
    localparam logic [EXT_W-1:0] LARGE_HEAP_SIZE = EXT_W'(LARGE_BLOCKS) << LARGE_BLOCK_SHIFT;

    localparam logic [SIZE_W-1:0] LARGE_BLOCK_BYTES = SIZE_W'(1) << LARGE_BLOCK_SHIFT;
    localparam logic [SIZE_W-1:0] SMALL_BLOCK_BYTES = SIZE_W'(1) << SMALL_BLOCK_SHIFT;

    // Stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W  = BYTES_W + ID_W + ADDR_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + ID_W + ADDR_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Block marks
    typedef logic [MARK_W-1:0] mark_t;
    localparam mark_t MARK_FREE      = 3'd0;
    localparam mark_t MARK_START     = 3'd1;
    localparam mark_t MARK_END       = 3'd2;
    localparam mark_t MARK_START_END = 3'd3;
    localparam mark_t MARK_MID       = 3'd4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC      = 2'd0,
        ACT_FREE       = 2'd1,
        ACT_ID_TO_ADDR = 2'd2,
        ACT_ADDR_TO_ID = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_SPACE = 2'd1,
        STATUS_RANGE    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_EV,
        S_MARK,
        S_FREE_RD,
        S_FREE_EV,
        S_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;
        logic clear_step;
        logic ptr_zero;
        logic scan_step;
        logic mark_step;
        logic free_start;
        logic free_step;
        logic conv;
        logic alloc_fail;
        logic alloc_ok;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    too_big;
        logic    free_in_range;
        logic    run_hit;
        logic    at_last;
        logic    mark_last;
        logic    rd_start;
        logic    rd_end;
        logic    free_head;
        logic    out_busy;
        logic    clear_done;
    } dp_status_t;

endpackage

// ===== src/two_heap_block_map_allocator.sv =====
// ----------------------------------------------------------------------------
// two_heap_block_map_allocator: first-fit allocator over two block maps
//
//   Channel   Ports                    Contents
//   -------   ----------------------   ---------------------------------------
//   request   s_tvalid/s_tready        s_tuser: action; s_tdata: request_bytes,
//                                      block_id, lookup_address
//   result    m_tvalid/m_tready        m_tdata: status, result_id,
//                                      result_address
//   config    cfg_wr_en                cfg_wr_data: heap_base
//
// After reset a clearing pass over as many entries as the larger map holds
// frees both maps; no request is taken until it ends.
// Allocation scans the map one entry at a time, since each map has a single
// port, and then marks the blocks of the run. Free walks the run block by
// block, the head block included. One request is in flight at a time; a
// result waits in the output register while the next request is
// processed.
// ----------------------------------------------------------------------------
module two_heap_block_map_allocator (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [thba_pkg::ADDR_W-1:0]          cfg_wr_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [31:0] request_bytes, [40:32] block_id, [88:41] lookup_address
    input  logic [thba_pkg::IN_TDATA_W-1:0]      s_tdata,
    // [1:0] action
    input  logic [thba_pkg::ACTION_W-1:0]        s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [1:0] status, [10:2] result_id, [58:11] result_address
    output logic [thba_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import thba_pkg::*;

    dp_cmd_t           cmd;
    dp_status_t        dp_sts;
    status_t           out_status;
    logic [ID_W-1:0]   out_result_id;
    logic [ADDR_W-1:0] out_result_address;

    thba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_sts   (dp_sts),
        .cmd      (cmd)
    );

    thba_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .dp_sts             (dp_sts),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_action          (action_t'(s_tuser)),
        .in_request_bytes   (s_tdata[BYTES_W-1:0]),
        .in_block_id        (s_tdata[BYTES_W +: ID_W]),
        .in_lookup_address  (s_tdata[BYTES_W+ID_W +: ADDR_W]),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_status         (out_status),
        .out_result_id      (out_result_id),
        .out_result_address (out_result_address)
    );

    assign m_tdata = OUT_TDATA_W'({out_result_address, out_result_id, out_status});

endmodule

// ===== src/thba_datapath.sv =====
// ----------------------------------------------------------------------------
// thba_datapath: block maps, walk pointer and result registers
// Holds both block maps, the captured request, the scan and free walk
// registers, the address conversion logic and the output register.
// ----------------------------------------------------------------------------
module thba_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  thba_pkg::dp_cmd_t              cmd,
    output thba_pkg::dp_status_t           dp_sts,
    input  logic                           cfg_wr_en,
    input  logic [thba_pkg::ADDR_W-1:0]    cfg_wr_data,
    input  thba_pkg::action_t              in_action,
    input  logic [thba_pkg::BYTES_W-1:0]   in_request_bytes,
    input  logic [thba_pkg::ID_W-1:0]      in_block_id,
    input  logic [thba_pkg::ADDR_W-1:0]    in_lookup_address,
    output logic                           out_valid,
    input  logic                           out_ready,
    output thba_pkg::status_t              out_status,
    output logic [thba_pkg::ID_W-1:0]      out_result_id,
    output logic [thba_pkg::ADDR_W-1:0]    out_result_address
);
    import thba_pkg::*;

    // Configuration
    logic [ADDR_W-1:0] heap_base_reg;
    logic [EXT_W-1:0]  large_base_reg;

    // Captured request
    action_t            action_reg;
    logic [ID_W-1:0]    id_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               sel_small_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               too_big_reg;
    logic               id_large_reg;
    logic               id_valid_reg;

    // Walk registers
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic [IDX_W-1:0]   first_reg;
    logic [IDX_W-1:0]   end_reg;
    logic               free_head_reg;

    // Maps
    mark_t large_map_mem [LARGE_BLOCKS];
    mark_t small_map_mem [SMALL_BLOCKS];
    mark_t large_rd_reg;
    mark_t small_rd_reg;

    // Results and output register
    status_t            res_status_reg;
    logic [ID_W-1:0]    res_id_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [ADDR_W-1:0]  out_addr_reg;

    // Request decode
    logic [SIZE_W-1:0]  bytes_ext;
    logic [SIZE_W-1:0]  cnt_large;
    logic [SIZE_W-1:0]  cnt_small;
    logic [SIZE_W-1:0]  req_cnt;
    logic [SIZE_W-1:0]  req_entries;
    logic               is_large_req;
    logic               ld_id_large;
    logic               ld_id_valid;

    // Walk helpers
    logic [CNT_W-1:0]   ptr_plus1;
    logic [CNT_W-1:0]   entries;
    logic [CNT_W-1:0]   run_plus1;
    mark_t              rd_mark;
    logic               rd_free;
    logic               run_hit;
    logic [IDX_W-1:0]   hit_first;
    logic [IDX_W-1:0]   free_idx;
    mark_t              mark_wdata;
    logic               wr_active;
    logic               large_we;
    logic               small_we;

    // Conversion
    logic [EXT_W-1:0]   conv_off;
    logic [EXT_W-1:0]   id_addr;
    logic [EXT_W-1:0]   diff_large;
    logic [EXT_W-1:0]   diff_small;
    logic               in_large;
    logic               in_small;
    status_t            conv_status;
    logic [ID_W-1:0]    conv_id;
    logic [ADDR_W-1:0]  conv_addr;

    // ------------------------------------------------------------------
    // Configuration register; the large heap base is kept precomputed.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg  <= '0;
            large_base_reg <= SMALL_HEAP_SIZE;
        end else if (cfg_wr_en) begin
            heap_base_reg  <= cfg_wr_data;
            large_base_reg <= EXT_W'(cfg_wr_data) + SMALL_HEAP_SIZE;
        end
    end

    // ------------------------------------------------------------------
    // Request capture
    // ------------------------------------------------------------------
    always_comb begin
        bytes_ext    = SIZE_W'(in_request_bytes);
        cnt_large    = (bytes_ext + LARGE_BLOCK_BYTES - SIZE_W'(1)) >> LARGE_BLOCK_SHIFT;
        cnt_small    = (bytes_ext + SMALL_BLOCK_BYTES - SIZE_W'(1)) >> SMALL_BLOCK_SHIFT;
        is_large_req = (bytes_ext >= LARGE_BLOCK_BYTES);
        if (is_large_req) begin
            req_cnt     = cnt_large;
            req_entries = SIZE_W'(LARGE_BLOCKS);
        end else begin
            // A zero-byte request still takes one small block.
            req_cnt     = (cnt_small == '0) ? SIZE_W'(1) : cnt_small;
            req_entries = SIZE_W'(SMALL_BLOCKS);
        end
        ld_id_large = (INT_W'(in_block_id) < INT_W'(LARGE_BLOCKS));
        ld_id_valid = (INT_W'(in_block_id) < INT_W'(LARGE_BLOCKS + SMALL_BLOCKS));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            action_reg    <= in_action;
            id_reg        <= in_block_id;
            addr_reg      <= in_lookup_address;
            sel_small_reg <= (in_action == ACT_ALLOC) ? !is_large_req : !ld_id_large;
            count_reg     <= CNT_W'(req_cnt);
            too_big_reg   <= (req_cnt > req_entries);
            id_large_reg  <= ld_id_large;
            id_valid_reg  <= ld_id_valid;
        end
    end

    // ------------------------------------------------------------------
    // Walk pointer, run length and run bounds
    // ------------------------------------------------------------------
    always_comb begin
        ptr_plus1 = CNT_W'(ptr_reg) + CNT_W'(1);
        entries   = sel_small_reg ? CNT_W'(SMALL_BLOCKS) : CNT_W'(LARGE_BLOCKS);
        run_plus1 = run_reg + CNT_W'(1);
        rd_mark   = sel_small_reg ? small_rd_reg : large_rd_reg;
        rd_free   = (rd_mark == MARK_FREE);
        run_hit   = rd_free && (run_plus1 == count_reg);
        hit_first = IDX_W'(ptr_plus1 - count_reg);
        if (id_large_reg) begin
            free_idx = IDX_W'(id_reg);
        end else begin
            free_idx = IDX_W'(INT_W'(id_reg) - INT_W'(LARGE_BLOCKS));
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        run_next = run_reg;
        if (cmd.clear_step || cmd.mark_step || cmd.free_step) begin
            ptr_next = IDX_W'(ptr_plus1);
        end else if (cmd.ptr_zero) begin
            ptr_next = '0;
            run_next = '0;
        end else if (cmd.scan_step) begin
            // On a hit the pointer jumps back to the head of the run.
            ptr_next = run_hit ? hit_first : IDX_W'(ptr_plus1);
            run_next = rd_free ? run_plus1 : '0;
        end else if (cmd.free_start) begin
            ptr_next = free_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg       <= '0;
            run_reg       <= '0;
            free_head_reg <= 1'b0;
        end else begin
            ptr_reg <= ptr_next;
            run_reg <= run_next;
            if (cmd.free_start) begin
                free_head_reg <= 1'b1;
            end else if (cmd.free_step) begin
                free_head_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_step && run_hit) begin
            first_reg <= hit_first;
            end_reg   <= ptr_reg;
        end
    end

    // ------------------------------------------------------------------
    // Block maps
    // ------------------------------------------------------------------
    always_comb begin
        if (!cmd.mark_step) begin
            mark_wdata = MARK_FREE;
        end else if (ptr_reg == first_reg) begin
            mark_wdata = (count_reg == CNT_W'(1)) ? MARK_START_END : MARK_START;
        end else if (ptr_reg == end_reg) begin
            mark_wdata = MARK_END;
        end else begin
            mark_wdata = MARK_MID;
        end
        wr_active = cmd.mark_step || cmd.free_step;
        if (cmd.clear_step) begin
            large_we = (CNT_W'(ptr_reg) < CNT_W'(LARGE_BLOCKS));
            small_we = (CNT_W'(ptr_reg) < CNT_W'(SMALL_BLOCKS));
        end else begin
            large_we = wr_active && !sel_small_reg;
            small_we = wr_active && sel_small_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (large_we) begin
            large_map_mem[ptr_reg[L_IDX_W-1:0]] <= mark_wdata;
        end
        large_rd_reg <= large_map_mem[ptr_reg[L_IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (small_we) begin
            small_map_mem[ptr_reg[S_IDX_W-1:0]] <= mark_wdata;
        end
        small_rd_reg <= small_map_mem[ptr_reg[S_IDX_W-1:0]];
    end

    // ------------------------------------------------------------------
    // Id and address conversion
    // ------------------------------------------------------------------
    always_comb begin
        if (id_large_reg) begin
            conv_off = EXT_W'(free_idx) << LARGE_BLOCK_SHIFT;
            id_addr  = large_base_reg + conv_off;
        end else begin
            conv_off = EXT_W'(free_idx) << SMALL_BLOCK_SHIFT;
            id_addr  = EXT_W'(heap_base_reg) + conv_off;
        end
        // An address below a base borrows and lands far above the heap size.
        diff_large = EXT_W'(addr_reg) - large_base_reg;
        diff_small = EXT_W'(addr_reg) - EXT_W'(heap_base_reg);
        in_large   = (diff_large < LARGE_HEAP_SIZE);
        in_small   = (diff_small < SMALL_HEAP_SIZE);

        conv_status = STATUS_OK;
        conv_id     = '0;
        conv_addr   = '0;
        if (action_reg == ACT_ID_TO_ADDR) begin
            if (id_valid_reg) begin
                conv_addr = ADDR_W'(id_addr);
            end else begin
                conv_status = STATUS_RANGE;
            end
        end else if (in_large) begin
            conv_id = ID_W'(diff_large >> LARGE_BLOCK_SHIFT);
        end else if (in_small) begin
            conv_id = ID_W'(EXT_W'(LARGE_BLOCKS) + (diff_small >> SMALL_BLOCK_SHIFT));
        end else begin
            conv_status = STATUS_RANGE;
        end
    end

    // ------------------------------------------------------------------
    // Result and output registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            res_status_reg <= STATUS_OK;
            res_id_reg     <= '0;
            res_addr_reg   <= '0;
        end else if (cmd.alloc_fail) begin
            res_status_reg <= STATUS_NO_SPACE;
            res_id_reg     <= '0;
        end else if (cmd.alloc_ok) begin
            if (sel_small_reg) begin
                res_id_reg <= ID_W'(INT_W'(first_reg) + INT_W'(LARGE_BLOCKS));
            end else begin
                res_id_reg <= ID_W'(first_reg);
            end
        end else if (cmd.conv) begin
            res_status_reg <= conv_status;
            res_id_reg     <= conv_id;
            res_addr_reg   <= conv_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_addr_reg   <= res_addr_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_status         = out_status_reg;
    assign out_result_id      = out_id_reg;
    assign out_result_address = out_addr_reg;

    always_comb begin
        dp_sts.action        = action_reg;
        dp_sts.too_big       = too_big_reg;
        dp_sts.free_in_range = id_valid_reg;
        dp_sts.run_hit       = run_hit;
        dp_sts.at_last       = (ptr_plus1 == entries);
        dp_sts.mark_last     = (ptr_reg == end_reg);
        dp_sts.rd_start      = ((rd_mark & MARK_START) != '0);
        dp_sts.rd_end        = ((rd_mark & MARK_END) != '0);
        dp_sts.free_head     = free_head_reg;
        dp_sts.out_busy      = out_valid_reg && !out_ready;
        dp_sts.clear_done    = (ptr_plus1 == CNT_W'(MAX_BLOCKS));
    end

endmodule

// ===== src/thba_ctrl.sv =====
// ----------------------------------------------------------------------------
// thba_ctrl: sequencing state machine of the block map allocator
// Runs the clearing pass after reset, then for each request the first-fit
// scan and marking, the free walk, or a conversion, and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module thba_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  thba_pkg::dp_status_t   dp_sts,
    output thba_pkg::dp_cmd_t      cmd
);
    import thba_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (dp_sts.clear_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (dp_sts.action)
                    ACT_ALLOC: state_next = dp_sts.too_big ? S_RESP : S_SCAN_RD;
                    ACT_FREE:  state_next = dp_sts.free_in_range ? S_FREE_RD : S_RESP;
                    default:   state_next = S_RESP;
                endcase
            end
            S_SCAN_RD: state_next = S_SCAN_EV;
            S_SCAN_EV: begin
                if (dp_sts.run_hit) begin
                    state_next = S_MARK;
                end else if (dp_sts.at_last) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_MARK: begin
                if (dp_sts.mark_last) state_next = S_RESP;
            end
            S_FREE_RD: state_next = S_FREE_EV;
            S_FREE_EV: begin
                // The head of a freed run must carry a start mark.
                if (dp_sts.free_head && !dp_sts.rd_start) begin
                    state_next = S_RESP;
                end else if (dp_sts.rd_end || dp_sts.at_last) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_FREE_RD;
                end
            end
            S_RESP: begin
                if (!dp_sts.out_busy) state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_CLEAR: cmd.clear_step = 1'b1;
            S_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            S_DISPATCH: begin
                case (dp_sts.action)
                    ACT_ALLOC: begin
                        cmd.alloc_fail = dp_sts.too_big;
                        cmd.ptr_zero   = !dp_sts.too_big;
                    end
                    ACT_FREE: cmd.free_start = dp_sts.free_in_range;
                    default:  cmd.conv       = 1'b1;
                endcase
            end
            S_SCAN_EV: begin
                cmd.scan_step  = 1'b1;
                cmd.alloc_fail = !dp_sts.run_hit && dp_sts.at_last;
            end
            S_MARK: begin
                cmd.mark_step = 1'b1;
                cmd.alloc_ok  = dp_sts.mark_last;
            end
            S_FREE_EV: cmd.free_step = !dp_sts.free_head || dp_sts.rd_start;
            S_RESP:    cmd.out_load  = !dp_sts.out_busy;
            default: ;
        endcase
    end

endmodule

// ===== verif/two_heap_block_map_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_heap_block_map_allocator_tb: self-checking bench for the allocator
// Requests go in over the slave stream. A behavioral copy of both block maps
// and the heap base predicts every result, and the results from the master
// stream are checked in order against those predictions. Directed requests
// cover the rounding edges, the free rules and the address map at the
// extreme heap bases. Random traffic follows in phases with different idle
// and stall rates, and a long receiver hold-off makes the input back up.
// ----------------------------------------------------------------------------
module two_heap_block_map_allocator_tb;
    import thba_pkg::*;

    localparam longint unsigned SMALL_SPAN  = longint'(SMALL_BLOCKS) << SMALL_BLOCK_SHIFT;
    localparam longint unsigned LARGE_SPAN  = longint'(LARGE_BLOCKS) << LARGE_BLOCK_SHIFT;
    localparam longint unsigned HEAPS_SPAN  = SMALL_SPAN + LARGE_SPAN;
    localparam int              CYCLE_LIMIT = 8_000_000;
    localparam bit              LARGE_HEAP  = 1'b0;
    localparam bit              SMALL_HEAP  = 1'b1;

    typedef struct packed {
        status_t              status;
        logic [ID_W-1:0]      id;
        logic [ADDR_W-1:0]    address;
    } alloc_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [ADDR_W-1:0]      cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    // [31:0] request_bytes, [40:32] block_id, [88:41] lookup_address
    logic [IN_TDATA_W-1:0]  s_tdata;
    // [1:0] action
    logic [ACTION_W-1:0]    s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // [1:0] status, [10:2] result_id, [58:11] result_address
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of both block maps of the block under test.
    mark_t              heap_marks [2][MAX_BLOCKS];
    logic [ADDR_W-1:0]  model_heap_base;

    alloc_result_t      expected_results [$];
    alloc_result_t      next_expected;
    logic [ID_W-1:0]    live_blocks [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int n_alloc = 0, n_free = 0, n_conv = 0, n_no_space = 0, n_range = 0, n_settings = 0;

    logic [ID_W-1:0] zero_size_id, wide_run_id, one_large_id, two_large_id;

    two_heap_block_map_allocator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // First fit over one map; returns the first block of the run or -1.
    function automatic int claim_first_fit(input bit heap, input longint unsigned count);
        int entries;
        int run;
        int first;
        entries = (heap == SMALL_HEAP) ? SMALL_BLOCKS : LARGE_BLOCKS;
        run = 0;
        if (count == 0 || count > longint'(entries))
            return -1;
        for (int i = 0; i < entries; i++) begin
            if (heap_marks[heap][i] == MARK_FREE) begin
                run++;
                if (run == count) begin
                    first = i + 1 - run;
                    if (run == 1) begin
                        heap_marks[heap][first] = MARK_START_END;
                    end else begin
                        for (int k = first + 1; k < i; k++)
                            heap_marks[heap][k] = MARK_MID;
                        heap_marks[heap][first] = MARK_START;
                        heap_marks[heap][i] = MARK_END;
                    end
                    return first;
                end
            end else begin
                run = 0;
            end
        end
        return -1;
    endfunction

    // Clears from a start mark through the next end mark, bounded by the map.
    function automatic void release_run(input bit heap, input int idx);
        int    entries;
        mark_t m;
        bit    done;
        entries = (heap == SMALL_HEAP) ? SMALL_BLOCKS : LARGE_BLOCKS;
        if (idx >= entries || !heap_marks[heap][idx][0] || heap_marks[heap][idx] == MARK_MID)
            return;
        done = 1'b0;
        while (idx < entries && !done) begin
            m = heap_marks[heap][idx];
            heap_marks[heap][idx] = MARK_FREE;
            done = m[1] && (m != MARK_MID);
            idx++;
        end
    endfunction

    function automatic alloc_result_t predict_result(input action_t act,
                                                     input logic [BYTES_W-1:0] bytes,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [ADDR_W-1:0] addr);
        alloc_result_t   r;
        longint unsigned small_base, large_base, blocks, bytes64, id64, addr64;
        int              got;
        r.status   = STATUS_OK;
        r.id       = '0;
        r.address  = '0;
        bytes64    = bytes;
        id64       = id;
        addr64     = addr;
        small_base = model_heap_base;
        large_base = small_base + SMALL_SPAN;
        got        = 0;
        case (act)
            ACT_ALLOC: begin
                if (bytes64 >= (64'd1 << LARGE_BLOCK_SHIFT)) begin
                    blocks = (bytes64 + (64'd1 << LARGE_BLOCK_SHIFT) - 1) >> LARGE_BLOCK_SHIFT;
                    got = claim_first_fit(LARGE_HEAP, blocks);
                    if (got >= 0)
                        r.id = ID_W'(got);
                end else begin
                    blocks = (bytes64 + (64'd1 << SMALL_BLOCK_SHIFT) - 1) >> SMALL_BLOCK_SHIFT;
                    if (blocks == 0)
                        blocks = 1;
                    got = claim_first_fit(SMALL_HEAP, blocks);
                    if (got >= 0)
                        r.id = ID_W'(got + LARGE_BLOCKS);
                end
                if (got < 0) begin
                    r.status = STATUS_NO_SPACE;
                    r.id = '0;
                end
            end
            ACT_FREE: begin
                if (id64 < LARGE_BLOCKS)
                    release_run(LARGE_HEAP, int'(id64));
                else if (id64 < LARGE_BLOCKS + SMALL_BLOCKS)
                    release_run(SMALL_HEAP, int'(id64 - LARGE_BLOCKS));
            end
            ACT_ID_TO_ADDR: begin
                if (id64 < LARGE_BLOCKS)
                    r.address = ADDR_W'(large_base + (id64 << LARGE_BLOCK_SHIFT));
                else if (id64 < LARGE_BLOCKS + SMALL_BLOCKS)
                    r.address = ADDR_W'(small_base + ((id64 - LARGE_BLOCKS) << SMALL_BLOCK_SHIFT));
                else
                    r.status = STATUS_RANGE;
            end
            ACT_ADDR_TO_ID: begin
                // The large heap range wins where the two would overlap.
                if (addr64 >= large_base && addr64 < large_base + LARGE_SPAN)
                    r.id = ID_W'((addr64 - large_base) >> LARGE_BLOCK_SHIFT);
                else if (addr64 >= small_base && addr64 < small_base + SMALL_SPAN)
                    r.id = ID_W'(LARGE_BLOCKS + ((addr64 - small_base) >> SMALL_BLOCK_SHIFT));
                else
                    r.status = STATUS_RANGE;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] any_address();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [ID_W-1:0] any_id();
        return ID_W'($urandom_range(511));
    endfunction

    function automatic logic [BYTES_W-1:0] alloc_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return $urandom_range(255);
        else if (pick < 60)
            return $urandom_range(4095);
        else if (pick < 85)
            return $urandom_range(32'h1_0000, 32'h1000);
        else if (pick < 93)
            return $urandom_range(32'h10_0000, 32'h1000);
        else if (pick < 97)
            return $urandom_range(32'hFFFF_FFFF, 32'h10_0001);
        else
            return $urandom();
    endfunction

    // Offers one request, waits for its transfer and records the prediction.
    task automatic issue_request(input action_t act, input logic [BYTES_W-1:0] bytes,
                                 input logic [ID_W-1:0] id, input logic [ADDR_W-1:0] addr,
                                 output alloc_result_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, addr, id, bytes};
        do @(posedge aclk); while (!s_tready);
        r = predict_result(act, bytes, id, addr);
        expected_results.push_back(r);
        case (act)
            ACT_ALLOC: n_alloc++;
            ACT_FREE:  n_free++;
            default:   n_conv++;
        endcase
        if (r.status == STATUS_NO_SPACE)
            n_no_space++;
        if (r.status == STATUS_RANGE)
            n_range++;
        if (act == ACT_ALLOC && r.status == STATUS_OK)
            live_blocks.push_back(r.id);
        if (act == ACT_FREE) begin
            for (int i = live_blocks.size() - 1; i >= 0; i--)
                if (live_blocks[i] == id)
                    live_blocks.delete(i);
        end
    endtask

    // Stops offering and waits until every result has come back.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_heap_base(input logic [ADDR_W-1:0] base);
        settle_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= base;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        model_heap_base = base;
        n_settings++;
    endtask

    task automatic test_alloc_sizes();
        alloc_result_t r;
        // Each rounding edge of both heaps, then two sizes no heap can hold.
        issue_request(ACT_ALLOC, 32'd0, any_id(), any_address(), r);
        zero_size_id = r.id;
        issue_request(ACT_ALLOC, 32'd1, any_id(), any_address(), r);
        issue_request(ACT_ALLOC, 32'd64, any_id(), any_address(), r);
        issue_request(ACT_ALLOC, 32'd65, any_id(), any_address(), r);
        issue_request(ACT_ALLOC, 32'd4095, any_id(), any_address(), r);
        wide_run_id = r.id;
        issue_request(ACT_ALLOC, 32'd4096, any_id(), any_address(), r);
        one_large_id = r.id;
        issue_request(ACT_ALLOC, 32'd4097, any_id(), any_address(), r);
        two_large_id = r.id;
        issue_request(ACT_ALLOC, 32'hFFFF_FFFF, any_id(), any_address(), r);
        issue_request(ACT_ALLOC, 32'h20_0000, any_id(), any_address(), r);
    endtask

    task automatic test_free_rules();
        alloc_result_t r;
        // A mid mark and a free block are both left alone.
        issue_request(ACT_FREE, $urandom(), ID_W'(wide_run_id + 1), any_address(), r);
        issue_request(ACT_FREE, $urandom(), 9'd200, any_address(), r);
        issue_request(ACT_FREE, $urandom(), wide_run_id, any_address(), r);
        issue_request(ACT_FREE, $urandom(), zero_size_id, any_address(), r);
        issue_request(ACT_FREE, $urandom(), one_large_id, any_address(), r);
        issue_request(ACT_FREE, $urandom(), two_large_id, any_address(), r);
        // With the large map empty again, a run of the whole heap must fit.
        issue_request(ACT_ALLOC, 32'h10_0000, any_id(), any_address(), r);
        issue_request(ACT_FREE, $urandom(), r.id, any_address(), r);
    endtask

    task automatic test_conversions();
        alloc_result_t     r;
        logic [ADDR_W-1:0] bases [2];
        bases[0] = '1;
        bases[1] = '0;
        foreach (bases[b]) begin
            write_heap_base(bases[b]);
            issue_request(ACT_ID_TO_ADDR, $urandom(), 9'd0, any_address(), r);
            issue_request(ACT_ID_TO_ADDR, $urandom(), 9'd511, any_address(), r);
            issue_request(ACT_ADDR_TO_ID, $urandom(), any_id(), bases[b], r);
            issue_request(ACT_ADDR_TO_ID, $urandom(), any_id(),
                          bases[b] + ADDR_W'(HEAPS_SPAN) - 1'b1, r);
            issue_request(ACT_ADDR_TO_ID, $urandom(), any_id(),
                          bases[b] + ADDR_W'(HEAPS_SPAN), r);
            issue_request(ACT_ADDR_TO_ID, $urandom(), any_id(),
                          bases[b] - 1'b1, r);
        end
    endtask

    task automatic test_random_traffic(input int items, input int idle_pct,
                                       input int stall_pct, input logic [ADDR_W-1:0] base);
        alloc_result_t      r;
        int                 pick;
        action_t            act;
        logic [BYTES_W-1:0] bytes;
        logic [ID_W-1:0]    id;
        logic [ADDR_W-1:0]  addr;
        write_heap_base(base);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < items; n++) begin
            bytes = $urandom();
            id    = any_id();
            addr  = any_address();
            pick  = $urandom_range(99);
            if (pick < 40 && live_blocks.size() < 48) begin
                act   = ACT_ALLOC;
                bytes = alloc_size();
            end else if (pick < 75) begin
                act = ACT_FREE;
                if (pick < 70 && live_blocks.size() != 0)
                    id = live_blocks[$urandom_range(live_blocks.size() - 1)];
            end else if (pick < 85) begin
                act = ACT_ID_TO_ADDR;
            end else begin
                act = ACT_ADDR_TO_ID;
                // Mostly near the heaps, a little below and above them too.
                if (pick < 95)
                    addr = model_heap_base + ADDR_W'($urandom_range(32'h0010_5000))
                           - ADDR_W'(32'h1000);
            end
            issue_request(act, bytes, id, addr, r);
        end
    endtask

    task automatic test_backpressure();
        alloc_result_t r;
        settle_block();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 3000;
        for (int n = 0; n < 40; n++) begin
            if (n % 2 == 0 || live_blocks.size() == 0)
                issue_request(ACT_ALLOC, $urandom_range(200), any_id(),
                              any_address(), r);
            else
                issue_request(ACT_FREE, $urandom(), live_blocks[0], any_address(), r);
        end
    endtask

    // Result side: random stalls, or a held-off stretch when one is asked for.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing outstanding: tdata %h", m_tdata);
                error_count++;
            end else begin
                next_expected = expected_results.pop_front();
                if (m_tdata[1:0] !== next_expected.status) begin
                    $error("status: expected %0d, actual %0d",
                           next_expected.status, m_tdata[1:0]);
                    error_count++;
                end
                if (m_tdata[10:2] !== next_expected.id) begin
                    $error("result_id: expected %0d, actual %0d",
                           next_expected.id, m_tdata[10:2]);
                    error_count++;
                end
                if (m_tdata[58:11] !== next_expected.address) begin
                    $error("result_address: expected %h, actual %h",
                           next_expected.address, m_tdata[58:11]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= ACT_ALLOC;
        model_heap_base = '0;
        for (int h = 0; h < 2; h++)
            for (int i = 0; i < MAX_BLOCKS; i++)
                heap_marks[h][i] = MARK_FREE;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_alloc_sizes();
        test_free_rules();
        test_conversions();
        test_random_traffic(470, 0, 0, any_address());
        test_random_traffic(470, 58, 0, 48'hFFFF_FFFF_C000);
        test_random_traffic(470, 0, 58, 48'h0);
        test_random_traffic(470, 7, 7, any_address());
        test_backpressure();

        settle_block();
        repeat (1000) @(posedge aclk);
        $display("Checked %0d allocations, %0d frees and %0d conversions over %0d heap bases.",
                 n_alloc, n_free, n_conv, n_settings);
        $display("%0d allocations found no room, %0d requests fell outside both heaps.",
                 n_no_space, n_range);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
